FILE: rtl/core/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared constants, types and byte classification for the byte stream lexer.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int LINE_WIDTH_DEF   = 32;
    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF  = 63;
    localparam int QUEUE_DEPTH      = 4;
    localparam int TYPE_W           = 5;

    localparam logic [TYPE_W-1:0] TOK_EOF   = 5'd0;
    localparam logic [TYPE_W-1:0] TOK_GT    = 5'd1;
    localparam logic [TYPE_W-1:0] TOK_LT    = 5'd2;
    localparam logic [TYPE_W-1:0] TOK_LPAR  = 5'd3;
    localparam logic [TYPE_W-1:0] TOK_RPAR  = 5'd4;
    localparam logic [TYPE_W-1:0] TOK_LBRC  = 5'd5;
    localparam logic [TYPE_W-1:0] TOK_RBRC  = 5'd6;
    localparam logic [TYPE_W-1:0] TOK_SEMI  = 5'd7;
    localparam logic [TYPE_W-1:0] TOK_PLUS  = 5'd8;
    localparam logic [TYPE_W-1:0] TOK_MINUS = 5'd9;
    localparam logic [TYPE_W-1:0] TOK_STAR  = 5'd10;
    localparam logic [TYPE_W-1:0] TOK_SLASH = 5'd11;
    localparam logic [TYPE_W-1:0] TOK_EQ    = 5'd12;
    localparam logic [TYPE_W-1:0] TOK_COMMA = 5'd13;
    localparam logic [TYPE_W-1:0] TOK_CARET = 5'd14;
    localparam logic [TYPE_W-1:0] TOK_TILDE = 5'd15;
    localparam logic [TYPE_W-1:0] TOK_PCT   = 5'd16;
    localparam logic [TYPE_W-1:0] TOK_BANG  = 5'd17;
    localparam logic [TYPE_W-1:0] TOK_INT   = 5'd18;
    localparam logic [TYPE_W-1:0] TOK_IDENT = 5'd19;

    localparam logic RK_TEXT  = 1'b0;
    localparam logic RK_TOKEN = 1'b1;
    localparam logic IK_BYTE  = 1'b0;
    localparam logic IK_EOS   = 1'b1;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;

    typedef enum logic [4:0] {
        RX_LEAD = 5'b00001,
        RX_ZERO = 5'b00010,
        RX_DEC  = 5'b00100,
        RX_OCT  = 5'b01000,
        RX_HEX  = 5'b10000
    } t_radix;

    typedef struct packed {
        t_radix phase;
        logic   stopped;
    } t_conv_state;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    function automatic logic f_is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic f_is_dec(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic [TYPE_W-1:0] f_punct_type(input logic [7:0] b);
        logic [TYPE_W-1:0] t;
        case (b)
            8'h3E:   t = TOK_GT;
            8'h3C:   t = TOK_LT;
            8'h28:   t = TOK_LPAR;
            8'h29:   t = TOK_RPAR;
            8'h7B:   t = TOK_LBRC;
            8'h7D:   t = TOK_RBRC;
            8'h3B:   t = TOK_SEMI;
            8'h2B:   t = TOK_PLUS;
            8'h2D:   t = TOK_MINUS;
            8'h2A:   t = TOK_STAR;
            8'h2F:   t = TOK_SLASH;
            8'h3D:   t = TOK_EQ;
            8'h2C:   t = TOK_COMMA;
            8'h5E:   t = TOK_CARET;
            8'h7E:   t = TOK_TILDE;
            8'h25:   t = TOK_PCT;
            8'h21:   t = TOK_BANG;
            default: t = TOK_EOF;
        endcase
        return t;
    endfunction

    function automatic t_digit f_digit(input logic [7:0] b);
        t_digit d;
        d.valid = 1'b1;
        if (b inside {[8'h30:8'h39]}) begin
            d.value = 4'(b - 8'h30);
        end else if (b inside {[8'h61:8'h66]}) begin
            d.value = 4'(b - 8'h57);
        end else if (b inside {[8'h41:8'h46]}) begin
            d.value = 4'(b - 8'h37);
        end else begin
            d.valid = 1'b0;
            d.value = 4'd0;
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/bsl_conv.sv
// ----------------------------------------------------------------------------
// bsl_conv
// One digit step of the integer conversion: radix detection and saturating
// accumulate by the detected radix (10, 8 or 16).
// ----------------------------------------------------------------------------
module bsl_conv #(
    parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    i_start,
    input  logic [7:0]              i_byte,
    input  bsl_pkg::t_conv_state    i_state,
    input  logic [VALUE_WIDTH-1:0]  i_acc,
    output bsl_pkg::t_conv_state    o_state,
    output logic [VALUE_WIDTH-1:0]  o_acc
);
    import bsl_pkg::*;

    t_conv_state            w_cur;
    logic [VALUE_WIDTH-1:0] w_acc_cur;
    t_digit                 w_dig;
    logic                   w_step;
    logic [VALUE_WIDTH+4:0] w_ext;
    logic [VALUE_WIDTH+4:0] w_prod;
    logic [VALUE_WIDTH+4:0] w_sum;

    always_comb begin
        w_cur.phase   = i_start ? RX_LEAD : i_state.phase;
        w_cur.stopped = i_start ? 1'b0 : i_state.stopped;
        w_acc_cur     = i_start ? '0 : i_acc;
        w_dig         = f_digit(i_byte);
        o_state       = w_cur;
        w_step        = 1'b0;
        if (!w_cur.stopped) begin
            case (w_cur.phase)
                RX_LEAD: begin
                    if (i_byte == CH_ZERO) begin
                        o_state.phase = RX_ZERO;
                    end else begin
                        o_state.phase = RX_DEC;
                        w_step        = 1'b1;
                    end
                end
                RX_ZERO: begin
                    if (i_byte == CH_LX || i_byte == CH_UX) begin
                        o_state.phase = RX_HEX;
                    end else if (w_dig.valid && w_dig.value < 4'd8) begin
                        o_state.phase = RX_OCT;
                        w_step        = 1'b1;
                    end else begin
                        o_state.stopped = 1'b1;
                    end
                end
                RX_DEC: begin
                    if (w_dig.valid && w_dig.value < 4'd10) w_step = 1'b1;
                    else o_state.stopped = 1'b1;
                end
                RX_OCT: begin
                    if (w_dig.valid && w_dig.value < 4'd8) w_step = 1'b1;
                    else o_state.stopped = 1'b1;
                end
                RX_HEX: begin
                    if (w_dig.valid) w_step = 1'b1;
                    else o_state.stopped = 1'b1;
                end
                default: begin
                    o_state.stopped = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        w_ext = {5'd0, w_acc_cur};
        case (o_state.phase)
            RX_DEC:  w_prod = (w_ext << 3) + (w_ext << 1);
            RX_OCT:  w_prod = w_ext << 3;
            default: w_prod = w_ext << 4;
        endcase
        w_sum = w_prod + (VALUE_WIDTH+5)'(w_dig.value);
        o_acc = w_acc_cur;
        if (w_step) begin
            o_acc = (|w_sum[VALUE_WIDTH+4:VALUE_WIDTH]) ? '1 : w_sum[VALUE_WIDTH-1:0];
        end
    end

endmodule

FILE: rtl/core/bsl_rq.sv
// ----------------------------------------------------------------------------
// bsl_rq
// Result queue: takes up to two words per cycle, hands out one per cycle while i_ready is high.
// DEPTH must be a power of two and at least 4.
// ----------------------------------------------------------------------------
module bsl_rq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bsl_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  logic [WIDTH-1:0] i_data0,
    input  logic [WIDTH-1:0] i_data1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    import bsl_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_head;
    logic [PW-1:0]    r_tail;
    logic [CW-1:0]    r_count;
    logic             w_pop;
    logic [PW-1:0]    w_tail1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign w_pop   = o_valid && i_ready;
    assign w_tail1 = r_tail + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + PW'(i_push_n);
            r_head  <= r_head + PW'(w_pop);
            r_count <= r_count + CW'(i_push_n) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_tail] <= i_data0;
        if (i_push_n == 2'd2) r_mem[w_tail1] <= i_data1;
    end

endmodule

FILE: rtl/core/byte_stream_lexer_core.sv
// ----------------------------------------------------------------------------
// byte_stream_lexer_core
// Byte-at-a-time tokenizer: splits words on whitespace and tokens, emits
// punctuation and end-of-stream tokens, echoes word bytes, converts integers.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | kind, byte_value
//  out     | output    | o_out_valid / i_out_ready | result_kind .. last
//
// One input word per cycle while the queue has room: input register, one
// pass of classification and digit accumulate, then a 4-entry result queue.
// An input word yields zero, one or two results; output drains one per cycle
// while i_out_ready is high.
// Input stalls only while the queue holds more than two results.
// Reset (synchronous, active low) clears lexer state; line count restarts at 1.
// ----------------------------------------------------------------------------
module byte_stream_lexer_core #(
    parameter int LINE_WIDTH   = bsl_pkg::LINE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = bsl_pkg::LENGTH_WIDTH_DEF,
    parameter int VALUE_WIDTH  = bsl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [7:0]                  i_byte_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_result_kind,
    output logic [bsl_pkg::TYPE_W-1:0]  o_token_type,
    output logic [7:0]                  o_text_byte,
    output logic [VALUE_WIDTH-1:0]      o_int_value,
    output logic [LINE_WIDTH-1:0]       o_line_number,
    output logic [LENGTH_WIDTH-1:0]     o_word_length,
    output logic                        o_last
);
    import bsl_pkg::*;

    localparam int RW = 1 + TYPE_W + 8 + VALUE_WIDTH + LINE_WIDTH + LENGTH_WIDTH + 1;

    logic                    r_in_valid;
    logic                    r_in_kind;
    logic [7:0]              r_in_byte;

    logic                    r_in_word;
    logic                    r_is_num;
    logic [LINE_WIDTH-1:0]   r_line_count;
    logic [LINE_WIDTH-1:0]   r_word_line;
    logic [LENGTH_WIDTH-1:0] r_length;
    logic [VALUE_WIDTH-1:0]  r_acc;
    t_conv_state             r_conv;

    logic                    n_in_word;
    logic                    n_is_num;
    logic [LINE_WIDTH-1:0]   n_line_count;
    logic [LINE_WIDTH-1:0]   n_word_line;
    logic [LENGTH_WIDTH-1:0] n_length;
    logic [VALUE_WIDTH-1:0]  n_acc;
    t_conv_state             n_conv;

    logic                    w_room;
    logic                    w_fire;
    logic                    w_eos;
    logic                    w_space;
    logic [TYPE_W-1:0]       w_pt;
    logic                    w_tok;
    logic                    w_text;
    logic                    w_start;
    logic                    w_conv_num;
    t_conv_state             w_conv_next;
    logic [VALUE_WIDTH-1:0]  w_acc_next;
    logic [TYPE_W-1:0]       w_tok_type;
    logic [RW-1:0]           w_word_res;
    logic [RW-1:0]           w_tok_res;
    logic [RW-1:0]           w_text_res;
    logic [RW-1:0]           w_d0;
    logic [RW-1:0]           w_d1;
    logic [1:0]              w_push_n;
    logic [RW-1:0]           w_q_data;

    assign w_fire     = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_byte_value;
        end
    end

    assign w_eos      = (r_in_kind == IK_EOS);
    assign w_space    = !w_eos && f_is_space(r_in_byte);
    assign w_pt       = f_punct_type(r_in_byte);
    assign w_tok      = w_eos || (!w_space && w_pt != TOK_EOF);
    assign w_text     = !w_eos && !w_space && w_pt == TOK_EOF;
    assign w_start    = w_text && !r_in_word;
    assign w_conv_num = w_start ? f_is_dec(r_in_byte) : r_is_num;
    assign w_tok_type = w_eos ? TOK_EOF : w_pt;

    bsl_conv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
        .i_start (w_start),
        .i_byte  (r_in_byte),
        .i_state (r_conv),
        .i_acc   (r_acc),
        .o_state (w_conv_next),
        .o_acc   (w_acc_next)
    );

    always_comb begin
        n_in_word    = r_in_word;
        n_is_num     = r_is_num;
        n_line_count = r_line_count;
        n_word_line  = r_word_line;
        n_length     = r_length;
        n_acc        = r_acc;
        n_conv       = r_conv;
        if (w_fire) begin
            if (w_text) begin
                n_in_word = 1'b1;
                n_is_num  = w_conv_num;
                if (w_start) begin
                    n_word_line = r_line_count;
                    n_length    = LENGTH_WIDTH'(1);
                end else if (r_length != '1) begin
                    n_length = r_length + LENGTH_WIDTH'(1);
                end
                if (w_conv_num) begin
                    n_acc  = w_acc_next;
                    n_conv = w_conv_next;
                end else if (w_start) begin
                    n_acc = '0;
                end
            end else begin
                n_in_word = 1'b0;
                if (w_space && r_in_byte == CH_LF && r_line_count != '1) begin
                    n_line_count = r_line_count + LINE_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word    <= 1'b0;
            r_is_num     <= 1'b0;
            r_line_count <= LINE_WIDTH'(1);
            r_word_line  <= LINE_WIDTH'(1);
            r_length     <= '0;
            r_acc        <= '0;
            r_conv       <= '{phase: RX_LEAD, stopped: 1'b0};
        end else begin
            r_in_word    <= n_in_word;
            r_is_num     <= n_is_num;
            r_line_count <= n_line_count;
            r_word_line  <= n_word_line;
            r_length     <= n_length;
            r_acc        <= n_acc;
            r_conv       <= n_conv;
        end
    end

    always_comb begin
        w_word_res = {RK_TOKEN, (r_is_num ? TOK_INT : TOK_IDENT), 8'd0,
                      (r_is_num ? r_acc : {VALUE_WIDTH{1'b0}}), r_word_line, r_length, 1'b0};
        w_tok_res  = {RK_TOKEN, w_tok_type, 8'd0, {VALUE_WIDTH{1'b0}}, r_line_count,
                      {LENGTH_WIDTH{1'b0}}, 1'b1};
        w_text_res = {RK_TEXT, TOK_EOF, r_in_byte, {VALUE_WIDTH{1'b0}},
                      (w_start ? r_line_count : r_word_line), {LENGTH_WIDTH{1'b0}}, 1'b1};
        w_d0     = w_text_res;
        w_d1     = w_tok_res;
        w_push_n = 2'd0;
        if (w_fire) begin
            if (w_text) begin
                w_push_n = 2'd1;
            end else if (r_in_word) begin
                w_d0 = w_word_res;
                if (w_tok) begin
                    w_push_n = 2'd2;
                end else begin
                    w_d0[0]  = 1'b1;
                    w_push_n = 2'd1;
                end
            end else if (w_tok) begin
                w_d0     = w_tok_res;
                w_push_n = 2'd1;
            end
        end
    end

    bsl_rq #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_rq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_data0  (w_d0),
        .i_data1  (w_d1),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (w_q_data)
    );

    assign {o_result_kind, o_token_type, o_text_byte, o_int_value,
            o_line_number, o_word_length, o_last} = w_q_data;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for byte_stream_lexer_core. Bytes and end-of-stream
// words go in over a valid/ready channel while a local tokenizer model
// predicts the text and token results; every result taken from the output
// channel is compared field by field against the oldest prediction.
// Directed runs cover punctuation, whitespace, odd bytes, integer radixes
// and long words; random token streams run under several
// idle/stall mixes, plus one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb;
    import bsl_pkg::*;

    localparam int LW = LINE_WIDTH_DEF;
    localparam int NW = LENGTH_WIDTH_DEF;
    localparam int VW = VALUE_WIDTH_DEF;
    localparam logic [63:0] VALUE_MAX = (64'd1 << VW) - 64'd1;
    localparam int RANDOM_ITEMS = 800;
    localparam int LONG_WORD_BYTES = 64;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic              rkind;
        logic [TYPE_W-1:0] ttype;
        logic [7:0]        text;
        logic [VW-1:0]     value;
        logic [LW-1:0]     line_no;
        logic [NW-1:0]     length;
        logic              last;
    } t_lexeme;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_kind;
    logic [7:0]        i_byte_value;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_result_kind;
    logic [TYPE_W-1:0] o_token_type;
    logic [7:0]        o_text_byte;
    logic [VW-1:0]     o_int_value;
    logic [LW-1:0]     o_line_number;
    logic [NW-1:0]     o_word_length;
    logic              o_last;

    byte_stream_lexer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_byte_value  (i_byte_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_token_type  (o_token_type),
        .o_text_byte   (o_text_byte),
        .o_int_value   (o_int_value),
        .o_line_number (o_line_number),
        .o_word_length (o_word_length),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tokenizer model state
    logic          lx_in_word     = 1'b0;
    logic          lx_is_number   = 1'b0;
    logic [LW-1:0] lx_line        = 1;
    logic [LW-1:0] lx_start_line  = 1;
    logic [NW-1:0] lx_length      = '0;
    logic [VW-1:0] lx_value       = '0;
    t_radix        lx_radix       = RX_LEAD;
    logic          lx_stopped     = 1'b0;

    t_lexeme lexemes_due[$];
    int      error_count       = 0;
    int      items_sent        = 0;
    int      eos_sent          = 0;
    int      results_checked   = 0;
    int      send_idle_pct     = 0;
    int      out_stall_pct     = 0;
    int      ready_hold_cycles = 0;

    function automatic logic is_blank(input logic [7:0] b);
        return b == " " || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [TYPE_W-1:0] punct_code(input logic [7:0] b);
        case (b)
            ">":     return TOK_GT;
            "<":     return TOK_LT;
            "(":     return TOK_LPAR;
            ")":     return TOK_RPAR;
            "{":     return TOK_LBRC;
            "}":     return TOK_RBRC;
            ";":     return TOK_SEMI;
            "+":     return TOK_PLUS;
            "-":     return TOK_MINUS;
            "*":     return TOK_STAR;
            "/":     return TOK_SLASH;
            "=":     return TOK_EQ;
            ",":     return TOK_COMMA;
            "^":     return TOK_CARET;
            "~":     return TOK_TILDE;
            "%":     return TOK_PCT;
            "!":     return TOK_BANG;
            default: return TOK_EOF;
        endcase
    endfunction

    function automatic int digit_weight(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic void accumulate(input int radix, input int d);
        logic [63:0] wide;
        wide = {{(64-VW){1'b0}}, lx_value};
        if (wide > (VALUE_MAX - 64'(d)) / 64'(radix))
            lx_value = VW'(VALUE_MAX);
        else
            lx_value = VW'(wide * 64'(radix) + 64'(d));
    endfunction

    function automatic void convert_digit(input logic [7:0] b);
        int d;
        d = digit_weight(b);
        if (lx_stopped) return;
        case (lx_radix)
            RX_LEAD: begin
                if (b == CH_ZERO) begin
                    lx_radix = RX_ZERO;
                end else begin
                    lx_radix = RX_DEC;
                    accumulate(10, d);
                end
            end
            RX_ZERO: begin
                if (b == CH_LX || b == CH_UX) begin
                    lx_radix = RX_HEX;
                end else if (d >= 0 && d < 8) begin
                    lx_radix = RX_OCT;
                    accumulate(8, d);
                end else begin
                    lx_stopped = 1'b1;
                end
            end
            RX_DEC: begin
                if (d >= 0 && d < 10) accumulate(10, d);
                else lx_stopped = 1'b1;
            end
            RX_OCT: begin
                if (d >= 0 && d < 8) accumulate(8, d);
                else lx_stopped = 1'b1;
            end
            default: begin
                if (d >= 0) accumulate(16, d);
                else lx_stopped = 1'b1;
            end
        endcase
    endfunction

    function automatic void lex_one_word(input logic kind, input logic [7:0] b);
        t_lexeme           produced[$];
        t_lexeme           r;
        logic [TYPE_W-1:0] pt;
        pt = punct_code(b);
        if (kind == IK_EOS || is_blank(b) || pt != TOK_EOF) begin
            if (lx_in_word) begin
                r         = '0;
                r.rkind   = RK_TOKEN;
                r.ttype   = lx_is_number ? TOK_INT : TOK_IDENT;
                r.value   = lx_is_number ? lx_value : '0;
                r.line_no = lx_start_line;
                r.length  = lx_length;
                produced.push_back(r);
                lx_in_word = 1'b0;
            end
        end
        if (kind == IK_EOS || (!is_blank(b) && pt != TOK_EOF)) begin
            r         = '0;
            r.rkind   = RK_TOKEN;
            r.ttype   = (kind == IK_EOS) ? TOK_EOF : pt;
            r.line_no = lx_line;
            produced.push_back(r);
        end else if (is_blank(b)) begin
            if (b == CH_LF && lx_line != '1) lx_line++;
        end else begin
            if (!lx_in_word) begin
                lx_in_word    = 1'b1;
                lx_start_line = lx_line;
                lx_is_number  = (b >= CH_ZERO && b <= CH_NINE);
                lx_length     = '0;
                lx_value      = '0;
                lx_radix      = RX_LEAD;
                lx_stopped    = 1'b0;
            end
            if (lx_length != '1) lx_length++;
            if (lx_is_number) convert_digit(b);
            r         = '0;
            r.rkind   = RK_TEXT;
            r.text    = b;
            r.line_no = lx_start_line;
            produced.push_back(r);
        end
        if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
        foreach (produced[k]) lexemes_due.push_back(produced[k]);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_lexeme want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lexemes_due.size() == 0) begin
                $error("unexpected result: kind %0d type %0d text 0x%0h",
                       o_result_kind, o_token_type, o_text_byte);
                error_count++;
            end else begin
                want = lexemes_due.pop_front();
                check_field("result_kind", 64'(want.rkind), 64'(o_result_kind));
                check_field("token_type", 64'(want.ttype), 64'(o_token_type));
                check_field("text_byte", 64'(want.text), 64'(o_text_byte));
                check_field("int_value", 64'(want.value), 64'(o_int_value));
                check_field("line_number", 64'(want.line_no), 64'(o_line_number));
                check_field("word_length", 64'(want.length), 64'(o_word_length));
                check_field("last", 64'(want.last), 64'(o_last));
                results_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (ready_hold_cycles > 0) begin
            i_out_ready       <= 1'b0;
            ready_hold_cycles <= ready_hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_byte_value <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        lex_one_word(kind, b);
        items_sent++;
        if (kind == IK_EOS) eos_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_word(IK_BYTE, s[k]);
    endtask

    task automatic drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (lexemes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
    endtask

    task automatic test_punctuation();
        set_idling(0, 0);
        send_text("><(){};+-*/=,^~%!");
        send_word(IK_EOS, 8'h00);
        drain();
    endtask

    task automatic test_blanks_and_bytes();
        send_text("a\tb\nc");
        send_word(IK_BYTE, 8'h0B);
        send_text("d");
        send_word(IK_BYTE, 8'h0C);
        send_text("e");
        send_word(IK_BYTE, 8'h0D);
        send_text("f g");
        send_word(IK_BYTE, 8'h00);
        send_word(IK_BYTE, 8'hFF);
        send_word(IK_BYTE, 8'h80);
        send_text("\n");
        send_word(IK_EOS, 8'hFF);
        send_word(IK_EOS, 8'h5A);
        drain();
    endtask

    task automatic test_integers();
        send_text("0x1fG 0X 0 017 0189 42abc 9;\n0xAbC");
        send_word(IK_EOS, 8'hA5);
        drain();
    endtask

    task automatic test_long_word();
        for (int k = 0; k < LONG_WORD_BYTES; k++) send_word(IK_BYTE, "q");
        send_text(" ");
        drain();
    endtask

    task automatic send_fragment();
        string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        string hexch = "0123456789abcdefABCDEFxg";
        string punct = "><(){};+-*/=,^~%!";
        int    pick;
        int    len;
        pick = $urandom_range(99);
        if (pick < 25) begin
            send_word(IK_BYTE, alnum[$urandom_range(52)]);
            len = $urandom_range(7);
            repeat (len) send_word(IK_BYTE, alnum[$urandom_range(alnum.len() - 1)]);
        end else if (pick < 40) begin
            send_word(IK_BYTE, 8'(CH_ZERO + $urandom_range(1, 9)));
            len = ($urandom_range(3) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 4);
            repeat (len) send_word(IK_BYTE, 8'(CH_ZERO + $urandom_range(9)));
        end else if (pick < 48) begin
            send_word(IK_BYTE, CH_ZERO);
            send_word(IK_BYTE, $urandom_range(1) ? CH_LX : CH_UX);
            len = $urandom_range(18);
            repeat (len) send_word(IK_BYTE, hexch[$urandom_range(hexch.len() - 1)]);
        end else if (pick < 54) begin
            send_word(IK_BYTE, CH_ZERO);
            len = $urandom_range(23);
            repeat (len) send_word(IK_BYTE, 8'(CH_ZERO + $urandom_range(8)));
        end else if (pick < 72) begin
            send_word(IK_BYTE, punct[$urandom_range(punct.len() - 1)]);
        end else if (pick < 85) begin
            send_word(IK_BYTE, $urandom_range(1) ? 8'h20 : 8'($urandom_range(9, 13)));
        end else if (pick < 92) begin
            send_word(IK_BYTE, CH_LF);
        end else if (pick < 97) begin
            send_word(IK_BYTE, 8'($urandom_range(255)));
        end else begin
            send_word(IK_EOS, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_stream();
        int send_mix[4]  = '{0, 46, 0, 24};
        int stall_mix[4] = '{0, 0, 46, 24};
        int start;
        for (int p = 0; p < 4; p++) begin
            set_idling(send_mix[p], stall_mix[p]);
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS / 4) send_fragment();
            drain();
        end
    endtask

    task automatic test_output_backpressure();
        set_idling(0, 0);
        @(posedge i_clk) ready_hold_cycles = 300;
        repeat (30) send_text("ab;c,");
        drain();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = IK_BYTE;
        i_byte_value = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_punctuation();
        test_blanks_and_bytes();
        test_integers();
        test_long_word();
        test_random_stream();
        test_output_backpressure();

        $display("covered %0d input words (%0d end-of-stream), %0d results checked,",
                 items_sent, eos_sent, results_checked);
        $display("across four idle/stall mixes and one long output hold");
        if (error_count == 0) begin
            $display("byte_stream_lexer_core test passed");
        end else begin
            $display("byte_stream_lexer_core test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("byte_stream_lexer_core test failed");
        $finish;
    end

endmodule
